>>> hw/rtl/bmp_fb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP framebuffer writer package
// Shared types and constants for the BMP byte parser and framebuffer writer.
// ----------------------------------------------------------------------------
package bmp_fb_pkg;

   // Screen coordinates reach at most 4095, framebuffer address is 19 bits
   localparam int COORD_W  = 12;
   localparam int ADDR_W   = 19;
   localparam int PROD_W   = 25;
   localparam int COLOR_W  = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   // Header byte offsets
   localparam logic [5:0] OFF_SIG0     = 6'h00;
   localparam logic [5:0] OFF_SIG1     = 6'h01;
   localparam logic [5:0] OFF_WIDTH    = 6'h12;
   localparam logic [5:0] OFF_HEIGHT   = 6'h16;
   localparam logic [5:0] OFF_DEPTH    = 6'h1C;
   localparam logic [5:0] OFF_DEPTH_HI = 6'h1D;
   localparam logic [5:0] OFF_SIZE     = 6'h20;
   localparam logic [5:0] OFF_LAST_HDR = 6'd53;

   localparam logic [7:0]  SIG_B  = 8'h42;
   localparam logic [7:0]  SIG_M  = 8'h4D;
   localparam logic [15:0] BPP_24 = 16'd24;
   localparam logic [15:0] BPP_32 = 16'd32;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 1'b1;

   typedef enum logic [1:0] {
      MODE_HEADER = 2'd0,
      MODE_PIXEL  = 2'd1,
      MODE_PAD    = 2'd2,
      MODE_IDLE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_PIXEL     = 2'd0,
      KIND_BAD_SIG   = 2'd1,
      KIND_BAD_DEPTH = 2'd2,
      KIND_END       = 2'd3
   } kind_type;

   // One command from the parser to the writer
   typedef struct packed {
      kind_type             kind;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [COLOR_W-1:0]   color;
      logic                 image_end;
   } cmd_type;

endpackage

>>> hw/rtl/bmp_fb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP byte parser
// Walks the header, assembles pixels, tracks screen position and pushes one
// command per result into the command queue.
// ----------------------------------------------------------------------------
module bmp_fb_front
   import bmp_fb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_file_start,
   input  logic [9:0]            origin_x,
   input  logic [8:0]            origin_y,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   mode_type     mode_ff, mode_in, mode_cur;
   logic [5:0]   off_ff, off_in, off_cur;
   logic [7:0]   sig_ff, sig_in;
   logic [31:0]  width_ff, width_in;
   logic [31:0]  height_ff, height_in;
   logic [7:0]   bpp_lo_ff, bpp_lo_in;
   logic         is32_ff, is32_in;
   logic [31:0]  mw_m1_ff, mw_m1_in;
   logic [31:0]  mh_m1_ff, mh_m1_in;
   logic [1:0]   pad_ff, pad_in;
   logic [23:0]  acc_ff, acc_in;
   logic [1:0]   bip_ff, bip_in;
   logic [31:0]  col_ff, col_in;
   logic [31:0]  row_ff, row_in;
   logic [1:0]   pad_left_ff, pad_left_in;
   logic [31:0]  x_ff, x_in;
   logic [31:0]  y_ff, y_in;
   logic [31:0]  x_start_ff, x_start_in;

   logic         accept;
   logic         hdr, sig_bad, depth_bad, hdr_last, img_empty;
   logic         pix, pix_done, col_end, row_last;
   logic         pad_mode, pad_done, row_finish, img_done, on_screen;
   logic [1:0]   last_lane, pad24;
   logic [15:0]  depth_word;
   logic [31:0]  x_first, y_first;

   // Decode the current byte
   assign req_ready  = !q_full;
   assign accept     = req_valid && req_ready;
   assign mode_cur   = req_file_start ? MODE_HEADER : mode_ff;
   assign off_cur    = req_file_start ? OFF_SIG0 : off_ff;

   assign hdr        = accept && (mode_cur == MODE_HEADER);
   assign sig_bad    = hdr && (off_cur == OFF_SIG1) &&
                       ((sig_ff != SIG_B) || (req_data_byte != SIG_M));
   assign depth_word = {req_data_byte, bpp_lo_ff};
   assign depth_bad  = hdr && (off_cur == OFF_DEPTH_HI) &&
                       (depth_word != BPP_24) && (depth_word != BPP_32);
   assign hdr_last   = hdr && (off_cur == OFF_LAST_HDR);
   assign img_empty  = (width_ff == '0) || (height_ff == '0);

   assign last_lane  = is32_ff ? 2'd3 : 2'd2;
   assign pix        = accept && (mode_cur == MODE_PIXEL);
   assign pix_done   = pix && (bip_ff == last_lane);
   assign col_end    = (col_ff == mw_m1_ff);
   assign row_last   = (row_ff == mh_m1_ff);
   assign pad_mode   = accept && (mode_cur == MODE_PAD);
   assign pad_done   = pad_mode && (pad_left_ff == 2'd1);
   assign row_finish = (pix_done && col_end && (pad_ff == 2'd0)) || pad_done;
   assign img_done   = row_finish && row_last;
   assign on_screen  = (x_ff < 32'(SCREEN_WIDTH)) && (y_ff < 32'(SCREEN_HEIGHT));

   // Row padding of a 24-bit image equals the low two bits of the width magnitude
   assign pad24   = width_ff[31] ? (~width_ff[1:0] + 2'd1) : width_ff[1:0];
   assign x_first = width_ff[31] ? (32'(origin_x) + mw_m1_ff) : 32'(origin_x);
   assign y_first = height_ff[31] ? 32'(origin_y) : (32'(origin_y) + mh_m1_ff);

   // Next parse mode
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         case (mode_cur)
            MODE_HEADER: begin
               if (sig_bad || depth_bad) begin
                  mode_in = MODE_IDLE;
               end else if (hdr_last) begin
                  mode_in = img_empty ? MODE_IDLE : MODE_PIXEL;
               end else begin
                  mode_in = MODE_HEADER;
               end
            end
            MODE_PIXEL: begin
               if (pix_done && col_end) begin
                  if (pad_ff != 2'd0) begin
                     mode_in = MODE_PAD;
                  end else begin
                     mode_in = row_last ? MODE_IDLE : MODE_PIXEL;
                  end
               end else begin
                  mode_in = MODE_PIXEL;
               end
            end
            MODE_PAD: begin
               if (pad_done) begin
                  mode_in = row_last ? MODE_IDLE : MODE_PIXEL;
               end else begin
                  mode_in = MODE_PAD;
               end
            end
            default: mode_in = MODE_IDLE;
         endcase
      end
   end

   // Queue push and command contents
   always_comb begin
      q_push          = 1'b0;
      q_cmd           = '0;
      q_cmd.kind      = KIND_PIXEL;
      if (sig_bad) begin
         q_push     = 1'b1;
         q_cmd.kind = KIND_BAD_SIG;
      end else if (depth_bad) begin
         q_push     = 1'b1;
         q_cmd.kind = KIND_BAD_DEPTH;
      end else if (hdr_last && img_empty) begin
         q_push          = 1'b1;
         q_cmd.kind      = KIND_END;
         q_cmd.image_end = 1'b1;
      end else if (pix_done && on_screen) begin
         q_push          = 1'b1;
         q_cmd.kind      = KIND_PIXEL;
         q_cmd.x         = x_ff[COORD_W-1:0];
         q_cmd.y         = y_ff[COORD_W-1:0];
         q_cmd.color     = is32_ff ? {req_data_byte, acc_ff} :
                                     {8'h00, req_data_byte, acc_ff[15:0]};
         q_cmd.image_end = img_done;
      end else if (img_done) begin
         q_push          = 1'b1;
         q_cmd.kind      = KIND_END;
         q_cmd.image_end = 1'b1;
      end
   end

   // Header capture, pixel assembly and position tracking
   always_comb begin
      off_in      = off_ff;
      sig_in      = sig_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      bpp_lo_in   = bpp_lo_ff;
      is32_in     = is32_ff;
      mw_m1_in    = mw_m1_ff;
      mh_m1_in    = mh_m1_ff;
      pad_in      = pad_ff;
      acc_in      = acc_ff;
      bip_in      = bip_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      pad_left_in = pad_left_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      x_start_in  = x_start_ff;

      if (hdr) begin
         if (!sig_bad && !depth_bad && !hdr_last) begin
            off_in = off_cur + 6'd1;
         end
         if (off_cur == OFF_SIG0) begin
            sig_in = req_data_byte;
         end
         for (int k = 0; k < 4; k++) begin
            if (off_cur == OFF_WIDTH + 6'(k)) begin
               width_in[8*k +: 8] = req_data_byte;
            end
            if (off_cur == OFF_HEIGHT + 6'(k)) begin
               height_in[8*k +: 8] = req_data_byte;
            end
         end
         if (off_cur == OFF_DEPTH) begin
            bpp_lo_in = req_data_byte;
         end
         if (off_cur == OFF_DEPTH_HI) begin
            is32_in = (depth_word == BPP_32);
         end
         // Magnitude minus one: bitwise invert for negative values
         if (off_cur == OFF_SIZE) begin
            mw_m1_in = width_ff[31] ? ~width_ff : (width_ff - 32'd1);
            mh_m1_in = height_ff[31] ? ~height_ff : (height_ff - 32'd1);
         end
         if (hdr_last) begin
            pad_in     = is32_ff ? 2'd0 : pad24;
            bip_in     = 2'd0;
            col_in     = '0;
            row_in     = '0;
            x_in       = x_first;
            x_start_in = x_first;
            y_in       = y_first;
         end
      end

      // Collect pixel bytes, then step the column
      if (pix) begin
         if (!pix_done) begin
            acc_in[8*bip_ff +: 8] = req_data_byte;
            bip_in                = bip_ff + 2'd1;
         end else begin
            bip_in = 2'd0;
            if (col_end) begin
               col_in = '0;
               x_in   = x_start_ff;
               if (pad_ff != 2'd0) begin
                  pad_left_in = pad_ff;
               end
            end else begin
               col_in = col_ff + 32'd1;
               x_in   = width_ff[31] ? (x_ff - 32'd1) : (x_ff + 32'd1);
            end
         end
      end

      if (pad_mode) begin
         pad_left_in = pad_left_ff - 2'd1;
      end

      // Advance to the next row
      if (row_finish && !row_last) begin
         row_in = row_ff + 32'd1;
         y_in   = height_ff[31] ? (y_ff + 32'd1) : (y_ff - 32'd1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HEADER;
         off_ff      <= OFF_SIG0;
         bip_ff      <= 2'd0;
         col_ff      <= '0;
         row_ff      <= '0;
         pad_left_ff <= 2'd0;
      end else begin
         mode_ff     <= mode_in;
         off_ff      <= off_in;
         bip_ff      <= bip_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         pad_left_ff <= pad_left_in;
      end
   end

   // Header and pixel data registers
   always_ff @(posedge clock) begin
      sig_ff     <= sig_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
      bpp_lo_ff  <= bpp_lo_in;
      is32_ff    <= is32_in;
      mw_m1_ff   <= mw_m1_in;
      mh_m1_ff   <= mh_m1_in;
      pad_ff     <= pad_in;
      acc_ff     <= acc_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      x_start_ff <= x_start_in;
   end

   a_pad_nonzero: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_PAD) |-> (pad_left_ff != 2'd0))
      else $error("pad mode entered with no padding left");

   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_valid && req_ready))
      else $error("command pushed without an accepted byte");

endmodule

>>> hw/rtl/bmp_fb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP command queue
// Short FIFO of parser commands between the parser and the writer.
// ----------------------------------------------------------------------------
module bmp_fb_queue
   import bmp_fb_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output cmd_type  head_cmd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : (wr_ptr_ff + AW'(1));
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : (rd_ptr_ff + AW'(1));
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("command pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(DEPTH)))
      else $error("queue count beyond depth");

endmodule

>>> hw/rtl/bmp_fb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP framebuffer writer
// Turns queued commands into result beats, computing row * width + column.
// ----------------------------------------------------------------------------
module bmp_fb_back
   import bmp_fb_pkg::*;
#(
   parameter int SCREEN_WIDTH = 800
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  cmd_type              head_cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [ADDR_W-1:0]    rsp_pixel_address,
   output logic [COLOR_W-1:0]   rsp_pixel_color,
   output logic                 rsp_image_end
);

   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             kind_ff;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [COLOR_W-1:0]   color_ff;
   logic                 end_ff;
   logic [PROD_W-1:0]    prod;

   // Take a command whenever the output register is empty or draining
   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   // Framebuffer address
   assign prod    = PROD_W'(head_cmd.y) * PROD_W'(SCREEN_WIDTH) + PROD_W'(head_cmd.x);
   assign addr_in = (head_cmd.kind == KIND_PIXEL) ? prod[ADDR_W-1:0] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the output beat
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= head_cmd.kind;
         addr_ff  <= addr_in;
         color_ff <= head_cmd.color;
         end_ff   <= head_cmd.image_end;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_pixel_address = addr_ff;
   assign rsp_pixel_color   = color_ff;
   assign rsp_image_end     = end_ff;

   a_marker_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff != KIND_PIXEL)) |-> ((addr_ff == '0) && (color_ff == '0)))
      else $error("non-pixel beat carries address or color");

endmodule

>>> hw/rtl/bmp_stream_to_framebuffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream to framebuffer unit
// Parses a 24/32-bit BMP byte stream and emits framebuffer pixel writes.
// ----------------------------------------------------------------------------
//  Channel | Ports                                        | Direction
//  --------+----------------------------------------------+----------
//  req     | req_valid/ready, req_data_byte, file_start   | in
//  rsp     | rsp_valid/ready, kind, pixel_address/color,  | out
//          | image_end                                    |
//  csr     | csr_valid/ready, csr_index, csr_wdata        | in
//
//  One byte per cycle is taken while the command queue has room; the parser
//  handles each byte in the cycle it is accepted and pushes at most one
//  command, which is stored in the queue; the writer loads the queue head
//  into its output register (row * width + column) when empty or draining.
//  Synchronous reset; no clearing pass, the unit is ready right after reset.
//  req_ready drops only while the command queue is full.
// ----------------------------------------------------------------------------
module bmp_stream_to_framebuffer_unit
   import bmp_fb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_file_start,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_kind,
   output logic [ADDR_W-1:0]       rsp_pixel_address,
   output logic [COLOR_W-1:0]      rsp_pixel_color,
   output logic                    rsp_image_end,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [9:0]   origin_x_ff, origin_x_in;
   logic [8:0]   origin_y_ff, origin_y_in;
   logic         q_full, q_push, q_pop, q_head_valid;
   cmd_type      q_cmd, q_head_cmd;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X: origin_x_in = csr_wdata[9:0];
            CSR_ORIGIN_Y: origin_y_in = csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
      end
   end

   bmp_fb_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_file_start (req_file_start),
      .origin_x       (origin_x_ff),
      .origin_y       (origin_y_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (q_cmd)
   );

   bmp_fb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd)
   );

   bmp_fb_back #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (q_head_valid),
      .head_cmd          (q_head_cmd),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_image_end     (rsp_image_end)
   );

endmodule

>>> verif/bmp_stream_to_framebuffer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP stream to framebuffer unit testbench
// Sends BMP files byte by byte, directed files first and then random ones,
// and checks every result beat against a behavioral parser kept in the
// bench. Both channels idle and stall at random; the origin registers are
// rewritten between files while nothing is in flight.
// ----------------------------------------------------------------------------
module bmp_stream_to_framebuffer_unit_tb;
   import bmp_fb_pkg::*;

   localparam int SCREEN_W      = 800;
   localparam int SCREEN_H      = 480;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_BOUND   = 50000;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_BYTES  = 100;
   localparam int NO_CAP        = 100000;

   typedef struct packed {
      kind_type             kind;
      logic [ADDR_W-1:0]    address;
      logic [COLOR_W-1:0]   color;
      logic                 image_end;
   } fb_write_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  req_file_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_kind;
   logic [ADDR_W-1:0]     rsp_pixel_address;
   logic [COLOR_W-1:0]    rsp_pixel_color;
   logic                  rsp_image_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ORIGIN_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   fb_write_type pending_writes[$];
   logic [7:0]  file_buf[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          rsp_hold = 0;
   bit          req_gaps_on = 1'b0;
   bit          rsp_stalls_on = 1'b0;

   // Parser state of the bench copy
   mode_type    bmp_mode = MODE_HEADER;
   logic [5:0]  bmp_offset = '0;
   logic [31:0] bmp_width = '0;
   logic [31:0] bmp_height = '0;
   logic [15:0] bmp_depth = '0;
   logic [31:0] bmp_acc = '0;
   logic [1:0]  bmp_byte_idx = '0;
   logic [31:0] bmp_col = '0;
   logic [31:0] bmp_row = '0;
   logic [1:0]  bmp_pad = '0;
   logic [9:0]  bmp_origin_x = '0;
   logic [8:0]  bmp_origin_y = '0;

   bmp_stream_to_framebuffer_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_file_start    (req_file_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_image_end     (rsp_image_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // --------------------------------------------------------------------
   // Bench parser
   // --------------------------------------------------------------------
   function automatic logic [31:0] dim_magnitude(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   // Close a row; report whether the whole pixel array is done
   function automatic bit close_row();
      bmp_col = '0;
      bmp_row = bmp_row + 32'd1;
      if (bmp_row >= dim_magnitude(bmp_height)) begin
         bmp_mode = MODE_IDLE;
         return 1'b1;
      end
      bmp_mode = MODE_PIXEL;
      return 1'b0;
   endfunction

   // Advance the parser by one byte; return 1 when the byte yields a beat
   function automatic bit decode_bmp_byte(input logic [7:0] value, input logic restart,
                                          output fb_write_type w);
      logic [1:0]  last_idx;
      logic [31:0] color, mw, mh;
      logic [1:0]  pad;
      longint      sx, sy, lw, lh, lcol, lrow, lox, loy;
      bit          visible, done;
      w = '0;
      done = 1'b0;
      if (restart) begin
         bmp_mode = MODE_HEADER;
         bmp_offset = '0;
         bmp_width = '0;
         bmp_height = '0;
         bmp_depth = '0;
         bmp_acc = '0;
         bmp_byte_idx = '0;
         bmp_col = '0;
         bmp_row = '0;
         bmp_pad = '0;
      end
      case (bmp_mode)
         MODE_IDLE: begin
            return 1'b0;
         end
         MODE_HEADER: begin
            if (bmp_offset == OFF_SIG1 && (bmp_acc != 32'(SIG_B) || value != SIG_M)) begin
               bmp_mode = MODE_IDLE;
               w.kind = KIND_BAD_SIG;
               return 1'b1;
            end
            if (bmp_offset == OFF_SIG0)
               bmp_acc = 32'(value);
            if (bmp_offset >= OFF_WIDTH && bmp_offset < OFF_WIDTH + 4)
               bmp_width = bmp_width | (32'(value) << (8 * (bmp_offset - OFF_WIDTH)));
            if (bmp_offset >= OFF_HEIGHT && bmp_offset < OFF_HEIGHT + 4)
               bmp_height = bmp_height | (32'(value) << (8 * (bmp_offset - OFF_HEIGHT)));
            if (bmp_offset == OFF_DEPTH)
               bmp_depth = 16'(value);
            if (bmp_offset == OFF_DEPTH_HI) begin
               bmp_depth = bmp_depth | (16'(value) << 8);
               if (bmp_depth != BPP_24 && bmp_depth != BPP_32) begin
                  bmp_mode = MODE_IDLE;
                  w.kind = KIND_BAD_DEPTH;
                  return 1'b1;
               end
            end
            if (bmp_offset == OFF_LAST_HDR) begin
               bmp_acc = '0;
               bmp_byte_idx = '0;
               if (bmp_width == 0 || bmp_height == 0) begin
                  bmp_mode = MODE_IDLE;
                  w.kind = KIND_END;
                  w.image_end = 1'b1;
                  return 1'b1;
               end
               bmp_mode = MODE_PIXEL;
            end else begin
               bmp_offset = bmp_offset + 6'd1;
            end
            return 1'b0;
         end
         MODE_PAD: begin
            bmp_pad = bmp_pad - 2'd1;
            if (bmp_pad == 0 && close_row()) begin
               w.kind = KIND_END;
               w.image_end = 1'b1;
               return 1'b1;
            end
            return 1'b0;
         end
         default: begin
            // Collect B, G, R (and A) until the pixel is complete
            last_idx = (bmp_depth == BPP_32) ? 2'd3 : 2'd2;
            if (bmp_byte_idx < last_idx) begin
               bmp_acc = bmp_acc | (32'(value) << (8 * bmp_byte_idx));
               bmp_byte_idx = bmp_byte_idx + 2'd1;
               return 1'b0;
            end
            if (last_idx == 2'd3)
               color = bmp_acc | (32'(value) << 24);
            else
               color = bmp_acc | (32'(value) << 16);
            bmp_acc = '0;
            bmp_byte_idx = '0;

            // Map to screen: mirror columns for negative width, rows for bottom-up
            mw = dim_magnitude(bmp_width);
            mh = dim_magnitude(bmp_height);
            lw = 64'(mw);
            lh = 64'(mh);
            lcol = 64'(bmp_col);
            lrow = 64'(bmp_row);
            lox = 64'(bmp_origin_x);
            loy = 64'(bmp_origin_y);
            sx = bmp_width[31] ? (lox + lw - 1 - lcol) : (lox + lcol);
            sy = bmp_height[31] ? (loy + lrow) : (loy + lh - 1 - lrow);
            visible = sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H;

            bmp_col = bmp_col + 32'd1;
            if (bmp_col >= mw) begin
               pad = (bmp_depth == BPP_32) ? 2'd0 : 2'(4 - ((mw * 3) & 3));
               if (pad != 0) begin
                  bmp_pad = pad;
                  bmp_mode = MODE_PAD;
               end else begin
                  done = close_row();
               end
            end

            if (visible) begin
               w.kind = KIND_PIXEL;
               w.address = ADDR_W'(sy * SCREEN_W + sx);
               w.color = color;
               w.image_end = done;
               return 1'b1;
            end
            if (done) begin
               w.kind = KIND_END;
               w.image_end = 1'b1;
               return 1'b1;
            end
            return 1'b0;
         end
      endcase
   endfunction

   // --------------------------------------------------------------------
   // Beat tracking and result checks
   // --------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      fb_write_type w;
      fb_write_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ORIGIN_X)
               bmp_origin_x = csr_wdata;
            else
               bmp_origin_y = csr_wdata[8:0];
         end
         if (req_valid && req_ready) begin
            if (decode_bmp_byte(req_data_byte, req_file_start, w))
               pending_writes.push_back(w);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_writes.size() == 0) begin
               $error("unexpected result beat: kind %0d address %0d", rsp_kind,
                      rsp_pixel_address);
               error_count++;
            end else begin
               want = pending_writes.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  error_count++;
               end
               if (rsp_pixel_address !== want.address) begin
                  $error("pixel_address: expected %0d, got %0d", want.address,
                         rsp_pixel_address);
                  error_count++;
               end
               if (rsp_pixel_color !== want.color) begin
                  $error("pixel_color: expected %h, got %h", want.color, rsp_pixel_color);
                  error_count++;
               end
               if (rsp_image_end !== want.image_end) begin
                  $error("image_end: expected %0d, got %0d", want.image_end, rsp_image_end);
                  error_count++;
               end
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // --------------------------------------------------------------------
   // Flow control
   // --------------------------------------------------------------------
   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   // Alternate ready runs and stalls on the result side
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold--;
      end else if (!rsp_stalls_on || $urandom_range(0, 3) != 0) begin
         rsp_ready <= 1'b1;
         rsp_hold = $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b0;
         rsp_hold = pick_gap();
      end
   end

   // Send one byte beat; valid stays up afterwards unless a gap follows
   task automatic send_byte(input logic [7:0] value, input logic restart);
      int gap;
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 99) >= 60)
         gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      req_file_start <= restart;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off until every expected beat has arrived and the pipe is quiet
   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes.size() != 0 && waited < DRAIN_BOUND) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both origin registers in one burst of two beats
   task automatic set_origin(input logic [9:0] x_word, input logic [9:0] y_word);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= CSR_ORIGIN_X;
      csr_wdata <= x_word;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_ORIGIN_Y;
      csr_wdata <= y_word;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // --------------------------------------------------------------------
   // File building
   // --------------------------------------------------------------------
   // Build header plus pixel array (capped) into file_buf
   function automatic void make_file(input logic [15:0] depth, input logic [31:0] w,
                                     input logic [31:0] h, input int px_cap);
      longint mw, mh, row_len, n;
      logic [7:0] v;
      file_buf.delete();
      for (int i = 0; i <= OFF_LAST_HDR; i++) begin
         v = 8'($urandom);
         if (i == OFF_SIG0)
            v = SIG_B;
         else if (i == OFF_SIG1)
            v = SIG_M;
         else if (i >= OFF_WIDTH && i < OFF_WIDTH + 4)
            v = w[8 * (i - OFF_WIDTH) +: 8];
         else if (i >= OFF_HEIGHT && i < OFF_HEIGHT + 4)
            v = h[8 * (i - OFF_HEIGHT) +: 8];
         else if (i == OFF_DEPTH)
            v = depth[7:0];
         else if (i == OFF_DEPTH_HI)
            v = depth[15:8];
         file_buf.push_back(v);
      end
      mw = 64'(dim_magnitude(w));
      mh = 64'(dim_magnitude(h));
      row_len = mw * ((depth == BPP_32) ? 4 : 3);
      if (depth != BPP_32)
         row_len = row_len + ((4 - (row_len % 4)) % 4);
      n = row_len * mh;
      if (n > px_cap)
         n = px_cap;
      for (longint i = 0; i < n; i++)
         file_buf.push_back(8'($urandom));
   endfunction

   task automatic send_file(input logic with_start, input int count);
      for (int i = 0; i < count && i < file_buf.size(); i++)
         send_byte(file_buf[i], with_start && i == 0);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom), 1'b0);
   endtask

   function automatic logic [31:0] pick_dimension();
      int r, m;
      r = $urandom_range(0, 99);
      if (r < 4)
         return 32'd0;
      m = (r < 80) ? $urandom_range(1, 4) : $urandom_range(5, 9);
      return ($urandom_range(0, 1) != 0) ? -32'(m) : 32'(m);
   endfunction

   function automatic logic [9:0] pick_origin_x();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15)
         return 10'd0;
      if (r < 30)
         return 10'($urandom_range(790, 799));
      if (r < 40)
         return 10'($urandom_range(800, 1023));
      return 10'($urandom_range(0, 799));
   endfunction

   // Bit 9 of the word is random: the register keeps only nine bits
   function automatic logic [9:0] pick_origin_y();
      int r;
      logic [8:0] y;
      r = $urandom_range(0, 99);
      if (r < 15)
         y = 9'd0;
      else if (r < 30)
         y = 9'($urandom_range(470, 479));
      else if (r < 40)
         y = 9'($urandom_range(480, 511));
      else
         y = 9'($urandom_range(0, 479));
      return {1'($urandom_range(0, 1)), y};
   endfunction

   // --------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------
   // First file right after reset, no start flag, reset origin, no idling
   task automatic test_first_file_without_start();
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      make_file(BPP_24, 32'd3, 32'd2, NO_CAP);
      send_file(1'b0, file_buf.size());
   endtask

   // Row and column flips, 0 to 2 bytes of padding, all-ones/all-zeros colors
   task automatic test_orientation();
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      set_origin(10'd10, {1'b1, 9'd20});
      make_file(BPP_24, 32'd1, 32'd2, NO_CAP);
      send_file(1'b1, file_buf.size());
      make_file(BPP_24, 32'd2, -32'd2, NO_CAP);
      send_file(1'b1, file_buf.size());
      make_file(BPP_24, 32'd4, 32'd1, NO_CAP);
      send_file(1'b1, file_buf.size());
      make_file(BPP_32, -32'd2, -32'd3, NO_CAP);
      for (int i = OFF_LAST_HDR + 1; i < OFF_LAST_HDR + 9; i++)
         file_buf[i] = (i < OFF_LAST_HDR + 5) ? 8'hFF : 8'h00;
      send_file(1'b1, file_buf.size());
   endtask

   // Images at the screen corner and fully beyond it
   task automatic test_clipping();
      set_origin(10'd798, 10'd478);
      make_file(BPP_32, 32'd3, 32'd3, NO_CAP);
      send_file(1'b1, file_buf.size());
      set_origin(10'h3FF, 10'h3FF);
      make_file(BPP_32, 32'd2, 32'd2, NO_CAP);
      send_file(1'b1, file_buf.size());
   endtask

   // Wrong first byte, wrong second byte, swapped pair; trailing bytes dropped
   task automatic test_bad_signature();
      make_file(BPP_24, 32'd2, 32'd2, NO_CAP);
      file_buf[0] = 8'h00;
      send_file(1'b1, 6);
      file_buf[0] = SIG_B;
      file_buf[1] = SIG_B;
      send_file(1'b1, 6);
      file_buf[0] = SIG_M;
      file_buf[1] = SIG_B;
      send_file(1'b1, 6);
      send_noise(8);
   endtask

   // Depth other than 24 or 32, including 24 with a nonzero high byte
   task automatic test_bad_depth();
      logic [15:0] depths[3];
      depths = '{16'd16, 16'h0118, 16'd0};
      foreach (depths[i]) begin
         make_file(depths[i], 32'd2, 32'd2, NO_CAP);
         send_file(1'b1, OFF_DEPTH_HI + 4);
      end
   endtask

   // Zero width or zero height end right at the last header byte
   task automatic test_empty_image();
      set_origin(10'd0, 10'd0);
      make_file(BPP_24, 32'd0, 32'd3, NO_CAP);
      send_file(1'b1, file_buf.size());
      make_file(BPP_32, 32'd5, 32'd0, NO_CAP);
      send_file(1'b1, file_buf.size());
      send_noise(5);
   endtask

   // Most negative height and width, cut short by the next file
   task automatic test_most_negative();
      set_origin(10'd5, 10'd7);
      make_file(BPP_32, 32'd1, 32'h8000_0000, 8);
      send_file(1'b1, file_buf.size());
      make_file(BPP_24, 32'h8000_0000, 32'd1, 6);
      send_file(1'b1, file_buf.size());
   endtask

   // Restart inside the header, inside a pixel and inside row padding
   task automatic test_restart_mid_file();
      make_file(BPP_24, 32'd1, 32'd3, NO_CAP);
      send_file(1'b1, 20);
      send_file(1'b1, OFF_LAST_HDR + 6);
      send_file(1'b1, OFF_LAST_HDR + 8);
   endtask

   // Mostly well-formed files with random content, plus broken ones and noise
   task automatic test_random_files();
      int sent, pick, count;
      logic [15:0] depth;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         req_gaps_on = ($urandom_range(0, 4) != 0);
         rsp_stalls_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 3) == 0)
            set_origin(pick_origin_x(), pick_origin_y());
         pick = $urandom_range(0, 99);
         depth = ($urandom_range(0, 1) != 0) ? BPP_32 : BPP_24;
         if (pick < 8) begin
            depth = ($urandom_range(0, 1) != 0) ? {8'($urandom_range(1, 255)), BPP_24[7:0]}
                                                 : 16'($urandom_range(0, 23));
         end
         make_file(depth, pick_dimension(), pick_dimension(), NO_CAP);
         if (pick >= 8 && pick < 14)
            file_buf[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
         count = file_buf.size();
         if (pick >= 14 && pick < 24)
            count = $urandom_range(1, file_buf.size());
         send_file(1'b1, count);
         sent += count;
         if (pick >= 88)
            send_noise($urandom_range(1, 12));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_first_file_without_start();
      test_orientation();
      test_clipping();
      test_bad_signature();
      test_bad_depth();
      test_empty_image();
      test_most_negative();
      test_restart_mid_file();
      test_random_files();

      // Let the last beats out, then look for leftovers
      drain_results();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (pending_writes.size() != 0) begin
         $error("%0d expected result beats never arrived", pending_writes.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
